// ===== hdl/suat_pkg.sv =====
// Shared types and constants for the sorted unique address table.
// Used by the controller, the datapath and the top level; depends on nothing.
package suat_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_BITS   = 24;
	localparam int LEN_BITS    = 24;
	localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
	localparam int OCNT_BITS   = 13;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FULL     = 3'd2,
		ST_FOUND    = 3'd3,
		ST_ABSENT   = 3'd4,
		ST_ZERO     = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;       // capture the accepted input item
		logic    srch_init;  // start the binary search
		logic    srch_rd;    // read the middle entry
		logic    srch_cmp;   // narrow the search window
		logic    sh_first;   // first read of the shift
		logic    sh_loop;    // move one entry up, read the next
		logic    ins_wr;     // write the new address, bump the count
		logic    q_rd;       // read the successor entry
		logic    set_res;    // latch a result status
		logic    set_len;    // latch the distance to the successor too
		status_t status;
		logic    out_load;   // move the result to the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero_key;
		logic is_query;
		logic lo_lt_hi;
		logic hit;
		logic full;
		logic succ;        // an entry follows the found position
		logic shift_need;  // entries lie at or above the insert point
		logic more;        // the shift goes on after this entry
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/suat_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; no package needed.
module suat_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/suat_datapath.sv =====
// Datapath of the address table: search window, shift pointer, count, result and output registers.
// Depends on suat_pkg and instantiates suat_ram for the address store.
module suat_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  suat_pkg::cmd_t                cmd,
	output suat_pkg::sts_t                sts,
	input  logic                          in_mode,
	input  logic [suat_pkg::ADDR_BITS-1:0] in_addr,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    out_status,
	output logic [suat_pkg::LEN_BITS-1:0]  out_length,
	output logic [suat_pkg::OCNT_BITS-1:0] out_count
);
	import suat_pkg::*;

	logic [ADDR_BITS-1:0] key_q;
	logic                 mode_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  lo_q;
	logic [CNT_BITS-1:0]  hi_q;
	logic                 eq_q;
	logic [CNT_BITS-1:0]  ptr_q;
	status_t              res_status_q;
	logic [LEN_BITS-1:0]  res_len_q;
	logic                 out_valid_q;
	logic [2:0]           out_status_q;
	logic [LEN_BITS-1:0]  out_length_q;
	logic [OCNT_BITS-1:0] out_count_q;

	logic [CNT_BITS-1:0]  mid;
	logic [CNT_BITS-1:0]  ptr_m1;
	logic [CNT_BITS-1:0]  ptr_m2;
	logic [CNT_BITS-1:0]  pos_p1;
	logic [ADDR_BITS-1:0] diff;

	logic                 ram_we;
	logic [IDX_BITS-1:0]  ram_waddr;
	logic [ADDR_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [IDX_BITS-1:0]  ram_raddr;
	logic [ADDR_BITS-1:0] ram_rdata;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign ptr_m1 = ptr_q - CNT_BITS'(1);
	assign ptr_m2 = ptr_q - CNT_BITS'(2);
	assign pos_p1 = hi_q + CNT_BITS'(1);
	assign diff   = ram_rdata - key_q;

	always_comb begin
		ram_re    = cmd.srch_rd | cmd.sh_first | cmd.sh_loop | cmd.q_rd;
		ram_raddr = mid[IDX_BITS-1:0];
		if (cmd.sh_first) begin
			ram_raddr = ptr_m1[IDX_BITS-1:0];
		end else if (cmd.sh_loop) begin
			ram_raddr = ptr_m2[IDX_BITS-1:0];
		end else if (cmd.q_rd) begin
			ram_raddr = pos_p1[IDX_BITS-1:0];
		end
		ram_we    = cmd.sh_loop | cmd.ins_wr;
		ram_waddr = cmd.sh_loop ? ptr_q[IDX_BITS-1:0] : hi_q[IDX_BITS-1:0];
		ram_wdata = cmd.sh_loop ? ram_rdata : key_q;
	end

	suat_ram #(
		.WIDTH(ADDR_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		sts.zero_key   = (key_q == '0);
		sts.is_query   = mode_q;
		sts.lo_lt_hi   = (lo_q < hi_q);
		sts.hit        = eq_q;
		sts.full       = (count_q == CNT_BITS'(TABLE_DEPTH));
		sts.succ       = (pos_p1 < count_q);
		sts.shift_need = (ptr_q > hi_q);
		sts.more       = (ptr_m1 > hi_q);
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_wr) begin
				count_q <= count_q + CNT_BITS'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= in_addr;
			mode_q <= in_mode;
		end
		if (cmd.srch_init) begin
			lo_q  <= '0;
			hi_q  <= count_q;
			eq_q  <= 1'b0;
			ptr_q <= count_q;
		end
		// The last entry that moved the upper bound decides whether the key is present.
		if (cmd.srch_cmp) begin
			if (ram_rdata < key_q) begin
				lo_q <= mid + CNT_BITS'(1);
			end else begin
				hi_q <= mid;
				eq_q <= (ram_rdata == key_q);
			end
		end
		if (cmd.sh_loop) begin
			ptr_q <= ptr_m1;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.status;
			res_len_q    <= cmd.set_len ? diff[LEN_BITS-1:0] : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_length_q <= res_len_q;
			out_count_q  <= OCNT_BITS'(count_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_length = out_length_q;
	assign out_count  = out_count_q;

endmodule

// ===== hdl/suat_ctrl.sv =====
// Controller state machine of the address table: sequences search, shift, insert and query.
// Depends on suat_pkg for the command and status structs.
module suat_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  suat_pkg::sts_t sts,
	output suat_pkg::cmd_t cmd
);
	import suat_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_COMPARE,
		S_DECIDE,
		S_SHIFT,
		S_INSERT,
		S_QREAD,
		S_QCALC,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.zero_key) begin
					cmd.set_res = 1'b1;
					cmd.status  = ST_ZERO;
					state_d     = S_RESP;
				end else begin
					cmd.srch_init = 1'b1;
					state_d       = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.lo_lt_hi) begin
					cmd.srch_rd = 1'b1;
					state_d     = S_COMPARE;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_COMPARE: begin
				cmd.srch_cmp = 1'b1;
				state_d      = S_SEARCH;
			end
			S_DECIDE: begin
				if (sts.is_query) begin
					if (sts.hit && sts.succ) begin
						cmd.q_rd = 1'b1;
						state_d  = S_QREAD;
					end else begin
						cmd.set_res = 1'b1;
						cmd.status  = ST_ABSENT;
						state_d     = S_RESP;
					end
				end else if (sts.hit) begin
					cmd.set_res = 1'b1;
					cmd.status  = ST_PRESENT;
					state_d     = S_RESP;
				end else if (sts.full) begin
					cmd.set_res = 1'b1;
					cmd.status  = ST_FULL;
					state_d     = S_RESP;
				end else if (sts.shift_need) begin
					cmd.sh_first = 1'b1;
					state_d      = S_SHIFT;
				end else begin
					state_d = S_INSERT;
				end
			end
			S_SHIFT: begin
				// One entry moves up each cycle while the next one is read.
				cmd.sh_loop = 1'b1;
				if (!sts.more) begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				cmd.ins_wr  = 1'b1;
				cmd.set_res = 1'b1;
				cmd.status  = ST_INSERTED;
				state_d     = S_RESP;
			end
			S_QREAD: begin
				state_d = S_QCALC;
			end
			S_QCALC: begin
				cmd.set_res = 1'b1;
				cmd.set_len = 1'b1;
				cmd.status  = ST_FOUND;
				state_d     = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/sorted_unique_address_table_top.sv =====
// Top level of the sorted unique address table: joins the controller and the datapath.
// Depends on suat_pkg, suat_ctrl and suat_datapath (which holds suat_ram).
//
// The block keeps up to 4096 unique nonzero 24-bit addresses in ascending order in one
// simple dual-port memory. Each transfer on the slave side is an insert (tuser 0) or a
// length query (tuser 1) and gives exactly one transfer on the master side. Items are
// handled one at a time. Each halving step of the binary search reads the middle entry
// in S_SEARCH and compares it in S_COMPARE, as each probe waits for the registered
// memory read. A new insert then moves every entry at or above its position up by one,
// one entry a cycle through the memory's single read and write ports. The finished
// result waits in an output register, and the next item is accepted while it is still
// untaken. The memory needs no clearing after reset, as only the first entry_count
// entries are ever read.
module sorted_unique_address_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[23:0]
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // length[23:0], entry_count[36:24], zeros[39:37]
	output logic [2:0]  m_tuser    // status[2:0]
);
	import suat_pkg::*;

	cmd_t                 cmd;
	sts_t                 sts;
	logic [2:0]           out_status;
	logic [LEN_BITS-1:0]  out_length;
	logic [OCNT_BITS-1:0] out_count;

	suat_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	suat_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_mode   (s_tuser),
		.in_addr   (s_tdata[ADDR_BITS-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(out_status),
		.out_length(out_length),
		.out_count (out_count)
	);

	assign m_tdata = {3'b000, out_count, out_length};
	assign m_tuser = out_status;

endmodule
